// File: rtl/fr_pkg.sv
// Package with shared constants, types and the division step for the reciprocal core.
package fr_pkg;

  localparam int unsigned NumSteps = 23;
  localparam logic [23:0] SigOne = 24'h800000;
  localparam logic [24:0] Dividend = 25'h1000000;
  localparam logic [7:0] ExpInf = 8'hff;

  // One item as it travels down the divider pipeline.
  typedef struct packed {
    logic        special;
    logic [31:0] spec_res;
    logic        sign;
    logic [7:0]  expo;
    logic        subnorm;
    logic [4:0]  nbits;
    logic [23:0] m;
    logic [24:0] rem;
    logic [23:0] q;
  } lane_t;

  // One restoring division step: shift, compare, subtract.
  function automatic lane_t div_step(lane_t l);
    lane_t       r;
    logic [25:0] sh;
    r = l;
    sh = {l.rem, 1'b0};
    if (sh >= {2'b00, l.m}) begin
      r.rem = 25'(sh - {2'b00, l.m});
      r.q = {l.q[22:0], 1'b1};
    end else begin
      r.rem = sh[24:0];
      r.q = {l.q[22:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: rtl/fr_in_if.sv
// Input channel interface carrying one operand per beat.
interface fr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_bits;
  modport source (output valid, output operand_bits, input ready);
  modport sink (input valid, input operand_bits, output ready);
endinterface

// File: rtl/fr_out_if.sv
// Output channel interface carrying one reciprocal per beat.
interface fr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] reciprocal_bits;
  modport source (output valid, output reciprocal_bits, input ready);
  modport sink (input valid, input reciprocal_bits, output ready);
endinterface

// File: rtl/fr_stage.sv
// One pipeline stage of the restoring divider.
module fr_stage
  import fr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [4:0] step_idx,
  input  logic       in_vld,
  input  lane_t      in_lane,
  output logic       out_vld,
  output lane_t      out_lane
);

  lane_t lane_next;

  // Items that need fewer quotient bits skip the trailing steps.
  always_comb begin
    if (!in_lane.special && (step_idx < in_lane.nbits)) begin
      lane_next = div_step(in_lane);
    end else begin
      lane_next = in_lane;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= lane_next;
    end
  end

endmodule

// File: rtl/fp32_reciprocal_core.sv
// Single-precision reciprocal: decode stage, 23 divider stages, rounding output register.
// The pipeline is a decode stage, 23 one-step restoring divider stages and a rounding stage.
// Throughput is one beat per cycle; the whole pipeline holds while the output waits.
// Reset clears all valid bits; payload registers are not reset.
module fp32_reciprocal_core
  import fr_pkg::*;
(
  input logic clk,
  input logic rst,
  fr_in_if.sink   in_ch,
  fr_out_if.source out_ch
);

  logic        adv;
  logic        vld [0:NumSteps];
  lane_t       pipe [0:NumSteps];
  lane_t       dec;
  logic [30:0] mag;
  logic [7:0]  ex;
  logic [22:0] frac;
  logic        out_valid;
  logic [31:0] out_data;
  logic [25:0] rem2;
  logic        up;
  logic [24:0] qr;
  logic [31:0] res_next;
  lane_t       last;

  assign adv = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_valid;
  assign out_ch.reciprocal_bits = out_data;

  assign mag = in_ch.operand_bits[30:0];
  assign ex = in_ch.operand_bits[30:23];
  assign frac = in_ch.operand_bits[22:0];

  // Classify the operand and set up the significand and result exponent.
  always_comb begin
    dec = '0;
    dec.sign = in_ch.operand_bits[31];
    dec.nbits = 5'd23;
    dec.m = SigOne | {1'b0, frac};
    if (mag <= 31'h200000) begin
      dec.special = 1'b1;
      dec.spec_res = {dec.sign, ExpInf, 23'd0};
    end else if (mag < 31'h800000) begin
      if (frac < 23'h400000) begin
        dec.m = {frac[21:0], 2'b00};
        dec.expo = 8'hfe;
      end else if (frac == 23'h400000) begin
        dec.special = 1'b1;
        dec.spec_res = {dec.sign, 8'hfe, 23'd0};
      end else begin
        dec.m = {frac, 1'b0};
        dec.expo = 8'hfd;
      end
    end else if (mag <= 31'h7e800000) begin
      if (frac == 23'd0) begin
        dec.special = 1'b1;
        dec.spec_res = {dec.sign, 8'(8'd254 - ex), 23'd0};
      end else begin
        dec.expo = 8'(8'd253 - ex);
      end
    end else if (mag < 31'h7f800000) begin
      dec.subnorm = 1'b1;
      if (mag < 31'h7f000000) begin
        dec.nbits = 5'd22;
      end else if (mag == 31'h7f000000) begin
        dec.special = 1'b1;
        dec.spec_res = {dec.sign, 31'h400000};
      end else begin
        dec.nbits = 5'd21;
      end
    end else if (mag == 31'h7f800000) begin
      dec.special = 1'b1;
      dec.spec_res = {dec.sign, 31'd0};
    end else begin
      dec.special = 1'b1;
      dec.spec_res = {dec.sign, ExpInf, frac | 23'h400000};
    end
    dec.rem = 25'(Dividend - {1'b0, dec.m});
    dec.q = 24'd1;
  end

  // Decode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= dec;
    end
  end

  // Divider stages, one quotient bit each.
  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    fr_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .step_idx (5'(i)),
      .in_vld   (vld[i]),
      .in_lane  (pipe[i]),
      .out_vld  (vld[i+1]),
      .out_lane (pipe[i+1])
    );
  end

  // Round to nearest even on the final remainder and pack the result.
  assign last = pipe[NumSteps];
  assign rem2 = {last.rem, 1'b0};
  assign up = (rem2 > {2'b00, last.m}) || ((rem2 == {2'b00, last.m}) && last.q[0]);
  assign qr = {1'b0, last.q} + {24'd0, up};

  always_comb begin
    if (last.special) begin
      res_next = last.spec_res;
    end else if (last.subnorm) begin
      res_next = {last.sign, 6'd0, qr};
    end else begin
      res_next = {last.sign, last.expo, qr[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NumSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res_next;
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the single-precision reciprocal core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandItems = 450;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainCycles = 40;

  // Scoreboard that predicts each reciprocal and checks results in order.
  class recip_scoreboard;
    logic [31:0] pending_recips[$];
    int unsigned fail_count;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned special_beats;

    function new();
      fail_count = 0;
      beats_in = 0;
      beats_out = 0;
      special_beats = 0;
    endfunction

    // Restoring division of 2^24 by m with nbits fraction bits, round to nearest even.
    function automatic logic [31:0] divide_sig(logic [31:0] m, int nbits);
      logic [31:0] rem;
      logic [31:0] q;
      rem = 32'h1000000 - m;
      q = 32'd1;
      for (int k = 0; k < nbits; k++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= m) begin
          rem = rem - m;
          q = q | 32'd1;
        end
      end
      rem = rem << 1;
      if (rem > m || (rem == m && q[0])) q = q + 32'd1;
      return q;
    endfunction

    function automatic logic [31:0] pack_fp(logic sgn, logic [7:0] ex, logic [31:0] frac);
      return {sgn, ex, frac[22:0]};
    endfunction

    function automatic logic [31:0] predict_recip(logic [31:0] a);
      logic        sgn;
      logic [31:0] mag;
      logic [7:0]  ex;
      logic [31:0] frac;
      sgn = a[31];
      mag = {1'b0, a[30:0]};
      ex = a[30:23];
      frac = {9'd0, a[22:0]};
      if (mag <= 32'h200000) return pack_fp(sgn, 8'hff, 0);
      if (mag < 32'h800000) begin
        if (frac < 32'h400000)
          return pack_fp(sgn, 8'hfe, divide_sig(frac << 2, 23) - 32'h800000);
        if (frac == 32'h400000) return pack_fp(sgn, 8'hfe, 0);
        return pack_fp(sgn, 8'hfd, divide_sig(frac << 1, 23) - 32'h800000);
      end
      if (mag <= 32'h7e800000) begin
        if (frac == 0) return pack_fp(sgn, 8'(254 - ex), 0);
        return pack_fp(sgn, 8'(253 - ex), divide_sig(32'h800000 | frac, 23) - 32'h800000);
      end
      if (mag < 32'h7f000000) return {sgn, 31'd0} | divide_sig(32'h800000 | frac, 22);
      if (mag == 32'h7f000000) return {sgn, 31'h400000};
      if (mag < 32'h7f800000) return {sgn, 31'd0} | divide_sig(32'h800000 | frac, 21);
      if (mag == 32'h7f800000) return pack_fp(sgn, 8'h00, 0);
      return pack_fp(sgn, 8'hff, frac | 32'h400000);
    endfunction

    function void note_operand(logic [31:0] a);
      beats_in++;
      if (a[30:23] == 8'hff || a[30:23] == 8'h00 || a[30:23] >= 8'hfd) special_beats++;
      pending_recips.push_back(predict_recip(a));
    endfunction

    function void check_recip(logic [31:0] got);
      logic [31:0] want;
      beats_out++;
      if (pending_recips.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        fail_count++;
        return;
      end
      want = pending_recips.pop_front();
      if (got !== want) begin
        $display("%0t: reciprocal_bits mismatch: expected %h actual %h", $time, want, got);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   no_idle;
  int unsigned idle_cycles;

  fr_in_if  in_ch ();
  fr_out_if out_ch ();

  fp32_reciprocal_core uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  recip_scoreboard sb = new();

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operand_bits = '0;
    out_ch.ready = 1'b0;
    no_idle = 1'b0;
  end

  // Sample both channels at each edge; the scoreboard sees beats in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_operand(in_ch.operand_bits);
      if (out_ch.valid && out_ch.ready) sb.check_recip(out_ch.reciprocal_bits);
    end
  end

  // Receiver stalls about a third of the time, except in the no-idle stretch.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= 33);
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Send one operand; random gaps come before the beat is offered.
  task automatic send_operand(logic [31:0] a);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operand_bits <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold the input idle until every result is back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_recips.size() != 0) @(posedge clk);
  endtask

  // Random operand aimed at each region of the input space.
  function automatic logic [31:0] rand_operand();
    logic [31:0] r;
    logic [7:0]  ex;
    r = $urandom();
    case ($urandom_range(9))
      0: ex = 8'h00;
      1: ex = 8'hff;
      2: ex = 8'($urandom_range(253, 254));
      3: ex = 8'($urandom_range(250, 252));
      4: ex = 8'($urandom_range(1, 3));
      default: ex = r[30:23];
    endcase
    r[30:23] = ex;
    if ($urandom_range(9) == 0) r[22:0] = 23'h0;
    else if ($urandom_range(9) == 0) r[22:0] = 23'h7fffff;
    return r;
  endfunction

  logic [31:0] directed_ops[] = '{
    32'h00000000, 32'h80000000, 32'h00000001, 32'h00200000, 32'h00200001,
    32'h003fffff, 32'h00400000, 32'h00400001, 32'h807fffff, 32'h00800000,
    32'h3f800000, 32'hbfc00000, 32'h3fffffff, 32'h7e800000, 32'h7e800001,
    32'h7effffff, 32'h7f000000, 32'hff000001, 32'h7f7fffff, 32'h7f800000,
    32'hff800000, 32'h7f800001, 32'hffc00000, 32'h7fffffff, 32'h40490fdb
  };

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed extremes and every special case, without idling.
    no_idle = 1'b1;
    foreach (directed_ops[i]) send_operand(directed_ops[i]);
    no_idle = 1'b0;

    // Random operands; one stretch runs with no idling, one pause drains the pipe.
    for (int i = 0; i < RandItems; i++) begin
      no_idle = (i >= 150 && i < 250);
      if (i == 300) wait_drained();
      send_operand(rand_operand());
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d operands (%0d near special exponents), checked %0d reciprocals.",
             sb.beats_in, sb.special_beats, sb.beats_out);
    if (sb.fail_count == 0 && sb.pending_recips.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
